FILE: hw/rtl/ipdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipdp_pkg: shared types and helpers for the dotted address parser
// character classes and the result word carried from the core to the top
// ----------------------------------------------------------------------------
package ipdp_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 32;

  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;

  typedef struct packed {
    logic             ok;
    logic [AddrW-1:0] addr;
  } res_t;

  function automatic logic is_term(input logic [CharW-1:0] c);
    return (c == ChNul) || (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_dec(input logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ipv4_dotted_address_parser.sv
`default_nettype none
// result: a terminator's result is registered as that word leaves the input register
// throughput: one character word per cycle; a terminator waits only while a
// previous result sits unread in the output register
// reset: synchronous active-low rst_n clears the parse state and both valid flags
// ----------------------------------------------------------------------------
// ipv4_dotted_address_parser: streaming dotted-quad address parser
// input register, per-character parse core, registered result
// ----------------------------------------------------------------------------
module ipv4_dotted_address_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [ipdp_pkg::CharW-1:0] in_character,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_valid_res,
  output logic [ipdp_pkg::AddrW-1:0]      out_address
);
  import ipdp_pkg::*;

  logic             s1_valid_r;
  logic [CharW-1:0] s1_char_r;
  logic             out_valid_r;
  res_t             out_res_r;
  res_t             core_res;
  logic             s1_term;
  logic             advance;

  assign s1_term  = is_term(s1_char_r);
  assign advance  = s1_valid_r && (!s1_term || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_char_r <= in_character;
    end
  end

  ipdp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .ch    (s1_char_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_term) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_term) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r.ok;
  assign out_address   = out_res_r.addr;

  // a failed parse reports a zero address
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.ok |-> out_res_r.addr == '0)
    else $error("invalid result with nonzero address");

  // a result only follows a terminator leaving the input register
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && s1_term))
    else $error("result without terminator");

  // input stalls only behind a held terminator and an unread result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s1_term && out_valid_r && !out_ready)
    else $error("unexpected input stall");

endmodule
`default_nettype wire

FILE: hw/rtl/ipdp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipdp_core: parse state and per-character update
// holds the part accumulator, saved parts and phase; gives the finished
// address for a terminator character in the same cycle
// ----------------------------------------------------------------------------
module ipdp_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [ipdp_pkg::CharW-1:0] ch,
  output ipdp_pkg::res_t                  res
);
  import ipdp_pkg::*;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_DIGITS = 3'd2
  } phase_t;

  typedef enum logic [1:0] {
    RDX_DEC = 2'd0,
    RDX_OCT = 2'd1,
    RDX_HEX = 2'd2
  } radix_t;

  phase_t           phase_r, phase_nxt;
  radix_t           radix_r, radix_nxt;
  logic [AddrW-1:0] acc_r, acc_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             err_r, err_nxt;
  logic [AddrW-1:0] part_r [3];
  logic             save;

  logic [AddrW-1:0] acc_mul;
  logic [3:0]       hex_val;
  logic             in_part;
  logic             is_hex_let;
  logic [AddrW-1:0] fin_v;
  logic             fin_ok;

  always_comb begin
    case (radix_r)
      RDX_OCT: acc_mul = acc_r << 3;
      RDX_HEX: acc_mul = acc_r << 4;
      default: acc_mul = (acc_r << 3) + (acc_r << 1);
    endcase
  end

  // a..f and A..F share the low three bits
  assign hex_val    = {1'b0, ch[2:0]} + 4'd9;
  assign is_hex_let = (radix_r == RDX_HEX) &&
                      ((ch >= ChLowA && ch <= ChLowF) || (ch >= ChUpA && ch <= ChUpF));
  assign in_part    = (phase_r == PH_ZERO) || (phase_r == PH_DIGITS);

  // last part fills what the earlier parts leave
  always_comb begin
    fin_v  = acc_r;
    fin_ok = 1'b1;
    case (cnt_r)
      2'd0: begin
        fin_v = acc_r;
      end
      2'd1: begin
        fin_ok = (acc_r[31:24] == '0);
        fin_v  = acc_r | (part_r[0] << 24);
      end
      2'd2: begin
        fin_ok = (acc_r[31:16] == '0);
        fin_v  = acc_r | (part_r[0] << 24) | (part_r[1] << 16);
      end
      default: begin
        fin_ok = (acc_r[31:8] == '0);
        fin_v  = acc_r | (part_r[0] << 24) | (part_r[1] << 16) | (part_r[2] << 8);
      end
    endcase
  end

  always_comb begin
    res.ok   = 1'b0;
    res.addr = '0;
    if (!err_r && in_part && fin_ok) begin
      res.ok   = 1'b1;
      res.addr = fin_v;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    save      = 1'b0;
    if (is_term(ch)) begin
      phase_nxt = PH_START;
      radix_nxt = RDX_DEC;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      err_nxt   = 1'b0;
    end else if (err_r) begin
      err_nxt = 1'b1;
    end else if (!in_part) begin
      if (!is_dec(ch)) begin
        err_nxt = 1'b1;
      end else if (ch == ChZero) begin
        acc_nxt   = '0;
        radix_nxt = RDX_OCT;
        phase_nxt = PH_ZERO;
      end else begin
        acc_nxt   = {{(AddrW-4){1'b0}}, ch[3:0]};
        radix_nxt = RDX_DEC;
        phase_nxt = PH_DIGITS;
      end
    end else if (phase_r == PH_ZERO && (ch == ChLowX || ch == ChUpX)) begin
      phase_nxt = PH_DIGITS;
      radix_nxt = RDX_HEX;
    end else begin
      phase_nxt = PH_DIGITS;
      if (is_dec(ch)) begin
        acc_nxt = acc_mul + {{(AddrW-4){1'b0}}, ch[3:0]};
      end else if (is_hex_let) begin
        acc_nxt = acc_mul | {{(AddrW-4){1'b0}}, hex_val};
      end else if (ch == ChDot) begin
        if (cnt_r == 2'd3) begin
          err_nxt = 1'b1;
        end else begin
          save      = 1'b1;
          cnt_nxt   = cnt_r + 2'd1;
          acc_nxt   = '0;
          radix_nxt = RDX_DEC;
          phase_nxt = PH_START;
        end
      end else begin
        err_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      radix_r <= RDX_DEC;
      acc_r   <= '0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && save) begin
      part_r[cnt_r] <= acc_r;
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_ipv4_dotted_address_parser.sv
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_address_parser: self-checking bench for the address parser
// feeds character words through the valid/ready input, predicts each parse
// result in a cycle-free model and checks every result word in order, under
// varying sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_ipv4_dotted_address_parser;
  import ipdp_pkg::*;

  typedef enum logic [1:0] {PART_START, LEAD_ZERO, IN_DIGITS} parse_phase_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CharW-1:0] in_character = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_valid_res;
  logic [AddrW-1:0] out_address;

  ipv4_dotted_address_parser dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_valid_res(out_valid_res),
    .out_address  (out_address)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  parse_phase_t     pp_phase = PART_START;
  logic [4:0]       pp_radix = 5'd10;
  logic [AddrW-1:0] pp_acc = '0;
  logic [AddrW-1:0] pp_parts [3];
  logic [1:0]       pp_count = '0;
  logic             pp_bad = 1'b0;

  res_t             results_due [$];
  logic [CharW-1:0] char_buf [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned chars_sent = 0;
  int unsigned results_seen = 0;
  int unsigned valid_seen = 0;
  int unsigned mismatch_count = 0;

  function automatic void restart_parse();
    pp_phase = PART_START;
    pp_radix = 5'd10;
    pp_acc   = '0;
    pp_count = '0;
    pp_bad   = 1'b0;
  endfunction

  function automatic void parse_char(logic [CharW-1:0] c);
    res_t             r;
    logic [AddrW-1:0] v;
    logic             term;
    logic             digit;
    term  = (c == ChNul) || (c == ChSpace) || (c >= ChTab && c <= ChCr);
    digit = (c >= ChZero) && (c <= ChNine);
    if (term) begin
      r = '0;
      if (!pp_bad && pp_phase != PART_START) begin
        v = pp_acc;
        r.ok = 1'b1;
        case (pp_count)
          2'd0: ;
          2'd1: begin
            r.ok = (v <= 32'h00ff_ffff);
            v = v | (pp_parts[0] << 24);
          end
          2'd2: begin
            r.ok = (v <= 32'h0000_ffff);
            v = v | (pp_parts[0] << 24) | (pp_parts[1] << 16);
          end
          default: begin
            r.ok = (v <= 32'h0000_00ff);
            v = v | (pp_parts[0] << 24) | (pp_parts[1] << 16) | (pp_parts[2] << 8);
          end
        endcase
        r.addr = r.ok ? v : '0;
      end
      results_due.push_back(r);
      restart_parse();
      return;
    end
    if (pp_bad) return;
    if (pp_phase == PART_START) begin
      if (!digit) begin
        pp_bad = 1'b1;
      end else if (c == ChZero) begin
        pp_acc   = '0;
        pp_radix = 5'd8;
        pp_phase = LEAD_ZERO;
      end else begin
        pp_acc   = AddrW'(c - ChZero);
        pp_radix = 5'd10;
        pp_phase = IN_DIGITS;
      end
      return;
    end
    if (pp_phase == LEAD_ZERO) begin
      pp_phase = IN_DIGITS;
      if (c == ChLowX || c == ChUpX) begin
        pp_radix = 5'd16;
        return;
      end
    end
    if (digit) begin
      pp_acc = pp_acc * AddrW'(pp_radix) + AddrW'(c - ChZero);
    end else if (pp_radix == 5'd16 && c >= ChLowA && c <= ChLowF) begin
      pp_acc = (pp_acc << 4) | AddrW'(c - ChLowA + 8'd10);
    end else if (pp_radix == 5'd16 && c >= ChUpA && c <= ChUpF) begin
      pp_acc = (pp_acc << 4) | AddrW'(c - ChUpA + 8'd10);
    end else if (c == ChDot) begin
      if (pp_count == 2'd3) begin
        pp_bad = 1'b1;
      end else begin
        pp_parts[pp_count] = pp_acc;
        pp_count = pp_count + 2'd1;
        pp_acc   = '0;
        pp_radix = 5'd10;
        pp_phase = PART_START;
      end
    end else begin
      pp_bad = 1'b1;
    end
  endfunction

  // one character word through the input handshake
  task automatic send_char(input logic [CharW-1:0] c);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= c;
    do @(posedge clk); while (!in_ready);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (char_buf[i]) send_char(char_buf[i]);
    char_buf = {};
  endtask

  task automatic send_string(input string s, input logic [CharW-1:0] term);
    for (int i = 0; i < s.len(); i++) char_buf.push_back(s[i]);
    char_buf.push_back(term);
    send_text();
  endtask

  function automatic void push_value(logic [AddrW-1:0] v, int unsigned base);
    logic [CharW-1:0] digits [$];
    int unsigned      d;
    while (v != 0) begin
      d = v % base;
      v = v / base;
      if (d < 10) digits.push_front(ChZero + CharW'(d));
      else digits.push_front(($urandom_range(1) ? ChUpA : ChLowA) + CharW'(d - 10));
    end
    foreach (digits[i]) char_buf.push_back(digits[i]);
  endfunction

  function automatic void push_part(logic [AddrW-1:0] v);
    case ($urandom_range(2))
      0: begin
        if (v == 0) char_buf.push_back(ChZero);
        else push_value(v, 10);
      end
      1: begin
        char_buf.push_back(ChZero);
        push_value(v, 8);
        if ($urandom_range(15) == 0) char_buf.push_back(ChNine - CharW'($urandom_range(1)));
      end
      default: begin
        char_buf.push_back(ChZero);
        char_buf.push_back($urandom_range(1) ? ChUpX : ChLowX);
        if (v != 0) push_value(v, 16);
        else if ($urandom_range(1)) char_buf.push_back(ChZero);
      end
    endcase
  endfunction

  function automatic void push_terminator();
    int unsigned r;
    r = $urandom_range(6);
    if (r == 0) char_buf.push_back(ChNul);
    else if (r == 1) char_buf.push_back(ChSpace);
    else char_buf.push_back(ChTab + CharW'(r - 2));
  endfunction

  function automatic void build_address();
    int unsigned      kind;
    int unsigned      nparts;
    logic [AddrW-1:0] v;
    logic [AddrW-1:0] field_max;
    kind = $urandom_range(99);
    if (kind < 78) begin
      nparts = $urandom_range(1, 4);
      for (int i = 0; i < nparts - 1; i++) begin
        v = ($urandom_range(9) == 0) ? AddrW'($urandom) : AddrW'($urandom_range(255));
        push_part(v);
        char_buf.push_back(ChDot);
      end
      field_max = 32'hffff_ffff >> (8 * (nparts - 1));
      case ($urandom_range(9))
        0: v = $urandom;
        1: v = field_max;
        2: v = field_max + 1;
        3: v = '0;
        default: v = $urandom & field_max;
      endcase
      push_part(v);
      if ($urandom_range(9) == 0)
        char_buf[$urandom_range(char_buf.size() - 1)] = CharW'($urandom_range(255));
    end else if (kind < 86) begin
      // fifth part or an empty part
      nparts = $urandom_range(1) ? 4 : $urandom_range(1, 3);
      for (int i = 0; i < nparts; i++) begin
        push_part($urandom_range(255));
        char_buf.push_back(ChDot);
      end
      if (nparts < 4) char_buf.push_back(ChDot);
      if ($urandom_range(1)) push_part($urandom_range(255));
    end else if (kind < 93) begin
      // long runs that wrap the accumulator
      if ($urandom_range(1)) begin
        char_buf.push_back(ChZero + CharW'($urandom_range(1, 9)));
        repeat ($urandom_range(9, 14)) char_buf.push_back(ChZero + CharW'($urandom_range(9)));
      end else begin
        char_buf.push_back(ChZero);
        char_buf.push_back(ChLowX);
        repeat ($urandom_range(9, 12)) push_value(AddrW'($urandom_range(1, 15)), 16);
      end
    end
    push_terminator();
  endfunction

  task automatic test_corner_cases();
    send_string("0x", ChSpace);
    send_string("09", 8'h0a);
    send_string("", 8'h0b);
    send_string("1.", ChCr);
    send_string("z9", ChSpace);
    char_buf.push_back(8'hff);
    send_string("", ChNul);
    send_string("0XfA", ChSpace);
    send_string("300.0", 8'h0c);
    send_string("0.0.0.256", ChNul);
  endtask

  task automatic test_address_stream(input int unsigned n);
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < n) begin
      build_address();
      send_text();
    end
  endtask

  task automatic test_garbage_recovery(input int unsigned n);
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < n) begin
      repeat ($urandom_range(1, 8)) char_buf.push_back(CharW'($urandom_range(255)));
      push_terminator();
      if ($urandom_range(1)) build_address();
      send_text();
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_valid_res) valid_seen++;
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: valid %0b address %08h",
                   out_valid_res, out_address);
      end else begin
        want = results_due.pop_front();
        if (want.ok !== out_valid_res || want.addr !== out_address) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d mismatch: expected valid %0b address %08h, got %0b %08h",
                     results_seen, want.ok, want.addr, out_valid_res, out_address);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    restart_parse();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_corner_cases();
    test_address_stream(400);

    send_idle_pct  = 62;
    recv_stall_pct = 0;
    test_address_stream(400);

    send_idle_pct  = 0;
    recv_stall_pct = 62;
    test_address_stream(400);
    test_garbage_recovery(150);

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    test_address_stream(400);

    @(negedge clk);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d characters over four handshake regimes", chars_sent);
    $display("checked %0d result words (%0d valid addresses), %0d mismatches",
             results_seen, valid_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ipdp_pkg.sv
hw/rtl/ipdp_core.sv
hw/rtl/ipv4_dotted_address_parser.sv
tb/tb_ipv4_dotted_address_parser.sv
